FILE: rtl/roa_pkg.sv
// Shared types, codes and reset constants for the obstacle avoidance navigator.
`timescale 1ns / 1ps

package roa_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int FLAG_W = 5;

  typedef enum logic [2:0] {
    NAV_IDLE   = 3'd0,
    NAV_FWD    = 3'd1,
    NAV_WALL_L = 3'd2,
    NAV_WALL_R = 3'd3,
    NAV_TURN_L = 3'd4,
    NAV_TURN_R = 3'd5,
    NAV_DONE   = 3'd6
  } roa_nav_t;

  typedef enum logic [1:0] {
    CMD_STOP  = 2'd0,
    CMD_FWD   = 2'd1,
    CMD_LEFT  = 2'd2,
    CMD_RIGHT = 2'd3
  } roa_cmd_t;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2
  } roa_req_t;

  typedef enum logic [2:0] {
    REG_SENSOR_PERIOD = 3'd0,
    REG_TURN_AVOID    = 3'd1,
    REG_WALL_FOLLOW   = 3'd2,
    REG_CRUISE_SPEED  = 3'd3,
    REG_WALL_SPEED    = 3'd4,
    REG_SEARCH_SPEED  = 3'd5,
    REG_AVOID_SPEED   = 3'd6
  } roa_reg_t;

  localparam int FL_IDX = 0;
  localparam int FC_IDX = 1;
  localparam int FR_IDX = 2;
  localparam int LS_IDX = 3;
  localparam int RS_IDX = 4;

  localparam logic [15:0] SENSOR_PERIOD_RST = 16'd50;
  localparam logic [15:0] TURN_AVOID_RST    = 16'd500;
  localparam logic [15:0] WALL_FOLLOW_RST   = 16'd3000;
  localparam logic [7:0]  CRUISE_SPEED_RST  = 8'd150;
  localparam logic [7:0]  WALL_SPEED_RST    = 8'd130;
  localparam logic [7:0]  SEARCH_SPEED_RST  = 8'd100;
  localparam logic [7:0]  AVOID_SPEED_RST   = 8'd120;

  typedef struct packed {
    logic [15:0] sensor_period_ms;
    logic [15:0] turn_avoid_ms;
    logic [15:0] wall_follow_ms;
    logic [7:0]  cruise_speed;
    logic [7:0]  wall_speed;
    logic [7:0]  search_turn_speed;
    logic [7:0]  avoid_turn_speed;
  } roa_cfg_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [31:0]       now_ms;
    logic [FLAG_W-1:0] flags;
  } roa_item_t;

  typedef struct packed {
    logic [1:0] motor_cmd;
    logic [7:0] speed;
    logic [2:0] nav_state;
  } roa_result_t;

endpackage

FILE: rtl/roa_if.sv
// Valid/ready channel interfaces for sensor words in and motor words out.
`timescale 1ns / 1ps

interface roa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] now_ms;
  logic        front_left;
  logic        front_center;
  logic        front_right;
  logic        left_side;
  logic        right_side;

  modport source(output valid, mode, now_ms, front_left, front_center, front_right,
                 left_side, right_side, input ready);
  modport sink(input valid, mode, now_ms, front_left, front_center, front_right,
               left_side, right_side, output ready);
endinterface

interface roa_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] motor_cmd;
  logic [7:0] speed;
  logic [2:0] nav_state;

  modport source(output valid, motor_cmd, speed, nav_state, input ready);
  modport sink(input valid, motor_cmd, speed, nav_state, output ready);
endinterface

FILE: rtl/roa_nav_core.sv
// Navigation state registers and the per-word decision logic.
`timescale 1ns / 1ps

module roa_nav_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  roa_pkg::roa_item_t   item,
  input  roa_pkg::roa_cfg_t    cfg,
  output logic                 res_valid,
  output roa_pkg::roa_result_t res
);

  logic                      running;
  logic                      running_next;
  roa_pkg::roa_nav_t         nav_mode;
  roa_pkg::roa_nav_t         nav_mode_next;
  logic [31:0]               mode_entry_ms;
  logic [31:0]               mode_entry_ms_next;
  logic [31:0]               last_sample_ms;
  logic [31:0]               last_sample_ms_next;
  logic [roa_pkg::FLAG_W-1:0] held_flags;
  logic [roa_pkg::FLAG_W-1:0] held_flags_next;

  logic [31:0]               since_sample;
  logic [31:0]               since_entry;
  logic [roa_pkg::FLAG_W-1:0] flags;
  logic                      any_front;
  logic                      enter_req;
  roa_pkg::roa_nav_t         enter_target;
  logic                      restamp;
  roa_pkg::roa_cmd_t         cmd;
  logic [7:0]                spd;

  assign since_sample = item.now_ms - last_sample_ms;
  assign since_entry  = item.now_ms - mode_entry_ms;
  assign flags = (since_sample >= {16'd0, cfg.sensor_period_ms}) ? item.flags : held_flags;
  assign any_front = flags[roa_pkg::FL_IDX] | flags[roa_pkg::FC_IDX] | flags[roa_pkg::FR_IDX];

  always_comb begin
    running_next        = running;
    last_sample_ms_next = last_sample_ms;
    held_flags_next     = held_flags;
    enter_req           = 1'b0;
    enter_target        = nav_mode;
    restamp             = 1'b0;
    res_valid           = 1'b0;
    cmd                 = roa_pkg::CMD_STOP;
    spd                 = 8'd0;

    case (roa_pkg::roa_req_t'(item.mode))
      roa_pkg::REQ_START: begin
        if (!running) begin
          running_next = 1'b1;
          enter_req    = 1'b1;
          enter_target = roa_pkg::NAV_FWD;
        end
      end
      roa_pkg::REQ_STOP: begin
        if (running) begin
          running_next = 1'b0;
          enter_req    = 1'b1;
          enter_target = roa_pkg::NAV_IDLE;
          res_valid    = 1'b1;
        end
      end
      roa_pkg::REQ_TICK: begin
        if (running) begin
          res_valid = 1'b1;
          if (since_sample >= {16'd0, cfg.sensor_period_ms}) begin
            held_flags_next     = item.flags;
            last_sample_ms_next = item.now_ms;
          end
          case (nav_mode)
            roa_pkg::NAV_FWD: begin
              if (any_front) begin
                enter_req = 1'b1;
                if (flags[roa_pkg::FL_IDX] && !flags[roa_pkg::FR_IDX]) begin
                  enter_target = roa_pkg::NAV_TURN_R;
                end else if (!flags[roa_pkg::FL_IDX] && flags[roa_pkg::FR_IDX]) begin
                  enter_target = roa_pkg::NAV_TURN_L;
                end else if (flags[roa_pkg::FC_IDX]) begin
                  enter_target = flags[roa_pkg::RS_IDX] ? roa_pkg::NAV_TURN_L
                                                        : roa_pkg::NAV_TURN_R;
                end else begin
                  enter_target = roa_pkg::NAV_TURN_L;
                end
              end else begin
                cmd = roa_pkg::CMD_FWD;
                spd = cfg.cruise_speed;
              end
            end
            roa_pkg::NAV_WALL_L, roa_pkg::NAV_WALL_R: begin
              if (flags[roa_pkg::FC_IDX]) begin
                enter_req    = 1'b1;
                enter_target = (nav_mode == roa_pkg::NAV_WALL_L) ? roa_pkg::NAV_TURN_R
                                                                 : roa_pkg::NAV_TURN_L;
              end else if ((nav_mode == roa_pkg::NAV_WALL_L) ? flags[roa_pkg::LS_IDX]
                                                             : flags[roa_pkg::RS_IDX]) begin
                cmd = roa_pkg::CMD_FWD;
                spd = cfg.wall_speed;
              end else begin
                cmd = (nav_mode == roa_pkg::NAV_WALL_L) ? roa_pkg::CMD_LEFT
                                                        : roa_pkg::CMD_RIGHT;
                spd = cfg.search_turn_speed;
              end
              if (since_entry > {16'd0, cfg.wall_follow_ms} && !any_front) begin
                enter_req    = 1'b1;
                enter_target = roa_pkg::NAV_FWD;
              end
            end
            roa_pkg::NAV_TURN_L, roa_pkg::NAV_TURN_R: begin
              cmd = (nav_mode == roa_pkg::NAV_TURN_L) ? roa_pkg::CMD_LEFT
                                                      : roa_pkg::CMD_RIGHT;
              spd = cfg.avoid_turn_speed;
              if (since_entry > {16'd0, cfg.turn_avoid_ms}) begin
                if (!any_front) begin
                  enter_req    = 1'b1;
                  enter_target = roa_pkg::NAV_FWD;
                end else if ((nav_mode == roa_pkg::NAV_TURN_L) ? flags[roa_pkg::LS_IDX]
                                                               : flags[roa_pkg::RS_IDX]) begin
                  enter_req    = 1'b1;
                  enter_target = (nav_mode == roa_pkg::NAV_TURN_L) ? roa_pkg::NAV_WALL_L
                                                                   : roa_pkg::NAV_WALL_R;
                end else begin
                  restamp = 1'b1;
                end
              end
            end
            default: begin
              cmd = roa_pkg::CMD_STOP;
              spd = 8'd0;
            end
          endcase
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase

    nav_mode_next      = nav_mode;
    mode_entry_ms_next = mode_entry_ms;
    if (enter_req && enter_target != nav_mode) begin
      nav_mode_next      = enter_target;
      mode_entry_ms_next = item.now_ms;
    end else if (restamp) begin
      mode_entry_ms_next = item.now_ms;
    end
  end

  assign res.motor_cmd = cmd;
  assign res.speed     = spd;
  assign res.nav_state = nav_mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      nav_mode       <= roa_pkg::NAV_IDLE;
      mode_entry_ms  <= 32'd0;
      last_sample_ms <= 32'd0;
      held_flags     <= '0;
    end else if (step) begin
      running        <= running_next;
      nav_mode       <= nav_mode_next;
      mode_entry_ms  <= mode_entry_ms_next;
      last_sample_ms <= last_sample_ms_next;
      held_flags     <= held_flags_next;
    end
  end

endmodule

FILE: rtl/reactive_obstacle_avoid_fsm.sv
// Top level of the obstacle avoidance navigator: register port, input and result stages.
//
// The sensor channel takes one word per handshake: a start request, a stop request or
// a tick carrying the millisecond time and five obstacle flags. The motor channel
// gives one word per running tick and per stop while running: motor command, speed
// and the navigation state after the step. Start requests, idle ticks and stray
// codes give no word.
// A word accepted from the sensor channel is registered in the input stage, decided there by the
// navigation core, and its result is registered in the output stage for the motor channel.
// One sensor word is taken every cycle while the motor channel does not stall; the only
// loop is the state update inside the decision stage.
// When the receiver stalls, the held motor word stays put and the input stage keeps
// accepting until its one slot holds a word that would produce a result.
// Words that give no result pass through the decision stage even during a stall.
// Users write configuration registers over the APB port only while the block is idle;
// the block does not enforce this. Reset clears both stages, stops navigation and
// restores the register defaults; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps

module reactive_obstacle_avoid_fsm (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [roa_pkg::ADDR_W-1:0] paddr,
  input  logic [roa_pkg::DATA_W-1:0] pwdata,
  output logic [roa_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  roa_in_if.sink                     sensor,
  roa_out_if.source                  motor
);

  roa_pkg::roa_cfg_t    cfg;
  logic                 in_valid;
  roa_pkg::roa_item_t   in_item;
  logic                 advance;
  logic                 res_valid;
  roa_pkg::roa_result_t res;
  logic                 out_valid;
  roa_pkg::roa_result_t out_word;
  roa_pkg::roa_reg_t    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = roa_pkg::roa_reg_t'(paddr[roa_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_period_ms  <= roa_pkg::SENSOR_PERIOD_RST;
      cfg.turn_avoid_ms     <= roa_pkg::TURN_AVOID_RST;
      cfg.wall_follow_ms    <= roa_pkg::WALL_FOLLOW_RST;
      cfg.cruise_speed      <= roa_pkg::CRUISE_SPEED_RST;
      cfg.wall_speed        <= roa_pkg::WALL_SPEED_RST;
      cfg.search_turn_speed <= roa_pkg::SEARCH_SPEED_RST;
      cfg.avoid_turn_speed  <= roa_pkg::AVOID_SPEED_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        roa_pkg::REG_SENSOR_PERIOD: cfg.sensor_period_ms  <= pwdata[15:0];
        roa_pkg::REG_TURN_AVOID:    cfg.turn_avoid_ms     <= pwdata[15:0];
        roa_pkg::REG_WALL_FOLLOW:   cfg.wall_follow_ms    <= pwdata[15:0];
        roa_pkg::REG_CRUISE_SPEED:  cfg.cruise_speed      <= pwdata[7:0];
        roa_pkg::REG_WALL_SPEED:    cfg.wall_speed        <= pwdata[7:0];
        roa_pkg::REG_SEARCH_SPEED:  cfg.search_turn_speed <= pwdata[7:0];
        roa_pkg::REG_AVOID_SPEED:   cfg.avoid_turn_speed  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      roa_pkg::REG_SENSOR_PERIOD: prdata = {16'd0, cfg.sensor_period_ms};
      roa_pkg::REG_TURN_AVOID:    prdata = {16'd0, cfg.turn_avoid_ms};
      roa_pkg::REG_WALL_FOLLOW:   prdata = {16'd0, cfg.wall_follow_ms};
      roa_pkg::REG_CRUISE_SPEED:  prdata = {24'd0, cfg.cruise_speed};
      roa_pkg::REG_WALL_SPEED:    prdata = {24'd0, cfg.wall_speed};
      roa_pkg::REG_SEARCH_SPEED:  prdata = {24'd0, cfg.search_turn_speed};
      roa_pkg::REG_AVOID_SPEED:   prdata = {24'd0, cfg.avoid_turn_speed};
      default:                    prdata = '0;
    endcase
  end

  assign advance      = in_valid && (!res_valid || !out_valid || motor.ready);
  assign sensor.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sensor.ready) begin
      in_valid <= sensor.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sensor.ready && sensor.valid) begin
      in_item.mode   <= sensor.mode;
      in_item.now_ms <= sensor.now_ms;
      in_item.flags  <= {sensor.right_side, sensor.left_side, sensor.front_right,
                         sensor.front_center, sensor.front_left};
    end
  end

  roa_nav_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (in_item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (motor.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_word <= res;
    end
  end

  assign motor.valid     = out_valid;
  assign motor.motor_cmd = out_word.motor_cmd;
  assign motor.speed     = out_word.speed;
  assign motor.nav_state = out_word.nav_state;

endmodule

FILE: rtl/roa_checker.sv
// Port-level assertions for the obstacle avoidance navigator, bound to the top level.
`timescale 1ns / 1ps

module roa_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] motor_cmd,
  input logic [7:0] speed,
  input logic [2:0] nav_state
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(motor_cmd) && $stable(speed)
                                && $stable(nav_state))
    else $error("Stalled motor word changed.");

  a_stop_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && motor_cmd == roa_pkg::CMD_STOP |-> speed == 8'd0)
    else $error("Stop command with nonzero speed.");

  a_idle_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && nav_state == roa_pkg::NAV_IDLE |-> motor_cmd == roa_pkg::CMD_STOP)
    else $error("Idle state reported with a moving command.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Motor word valid right after reset.");

endmodule

bind reactive_obstacle_avoid_fsm roa_checker u_roa_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (motor.valid),
  .out_ready (motor.ready),
  .motor_cmd (motor.motor_cmd),
  .speed     (motor.speed),
  .nav_state (motor.nav_state)
);

FILE: test/tb_reactive_obstacle_avoid_fsm.sv
// Self-checking testbench for the obstacle avoidance navigator: directed and random sensor words.
`timescale 1ns / 1ps

module tb_reactive_obstacle_avoid_fsm;

  localparam int CYCLE_LIMIT = 300000;
  localparam int FLAGS_W = roa_pkg::FLAG_W;
  localparam logic [2:0] REG_COUNT = 3'd7;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [FLAGS_W-1:0] F_FL = FLAGS_W'(1 << roa_pkg::FL_IDX);
  localparam logic [FLAGS_W-1:0] F_FC = FLAGS_W'(1 << roa_pkg::FC_IDX);
  localparam logic [FLAGS_W-1:0] F_FR = FLAGS_W'(1 << roa_pkg::FR_IDX);
  localparam logic [FLAGS_W-1:0] F_LS = FLAGS_W'(1 << roa_pkg::LS_IDX);
  localparam logic [FLAGS_W-1:0] F_RS = FLAGS_W'(1 << roa_pkg::RS_IDX);
  localparam logic [FLAGS_W-1:0] F_ALL = '1;

  class motor_scoreboard;
    roa_pkg::roa_cfg_t cfg;
    bit running;
    roa_pkg::roa_nav_t nav;
    logic [31:0] entry_ms;
    logic [31:0] sample_ms;
    logic [FLAGS_W-1:0] held;
    roa_pkg::roa_result_t pending_words[$];
    int failures;

    function new();
      cfg.sensor_period_ms = roa_pkg::SENSOR_PERIOD_RST;
      cfg.turn_avoid_ms = roa_pkg::TURN_AVOID_RST;
      cfg.wall_follow_ms = roa_pkg::WALL_FOLLOW_RST;
      cfg.cruise_speed = roa_pkg::CRUISE_SPEED_RST;
      cfg.wall_speed = roa_pkg::WALL_SPEED_RST;
      cfg.search_turn_speed = roa_pkg::SEARCH_SPEED_RST;
      cfg.avoid_turn_speed = roa_pkg::AVOID_SPEED_RST;
      running = 1'b0;
      nav = roa_pkg::NAV_IDLE;
      entry_ms = '0;
      sample_ms = '0;
      held = '0;
      failures = 0;
    endfunction

    function void fail(string what);
      failures++;
      if (failures <= 10) $display("%t: %s", $realtime, what);
    endfunction

    function void set_reg(logic [2:0] index, logic [31:0] value);
      case (index)
        roa_pkg::REG_SENSOR_PERIOD: cfg.sensor_period_ms = value[15:0];
        roa_pkg::REG_TURN_AVOID:    cfg.turn_avoid_ms = value[15:0];
        roa_pkg::REG_WALL_FOLLOW:   cfg.wall_follow_ms = value[15:0];
        roa_pkg::REG_CRUISE_SPEED:  cfg.cruise_speed = value[7:0];
        roa_pkg::REG_WALL_SPEED:    cfg.wall_speed = value[7:0];
        roa_pkg::REG_SEARCH_SPEED:  cfg.search_turn_speed = value[7:0];
        roa_pkg::REG_AVOID_SPEED:   cfg.avoid_turn_speed = value[7:0];
        default: ;
      endcase
    endfunction

    function void switch_mode(roa_pkg::roa_nav_t m, logic [31:0] now);
      if (m != nav) begin
        nav = m;
        entry_ms = now;
      end
    endfunction

    function void note_word(roa_pkg::roa_item_t w);
      roa_pkg::roa_result_t r;
      bit has;
      bit fl, fc, fr, ls, rs, left, any_front;
      logic [31:0] since;
      has = 1'b0;
      r.motor_cmd = roa_pkg::CMD_STOP;
      r.speed = '0;
      r.nav_state = roa_pkg::NAV_IDLE;
      case (w.mode)
        roa_pkg::REQ_START: begin
          if (!running) begin
            running = 1'b1;
            switch_mode(roa_pkg::NAV_FWD, w.now_ms);
          end
        end
        roa_pkg::REQ_STOP: begin
          if (running) begin
            running = 1'b0;
            switch_mode(roa_pkg::NAV_IDLE, w.now_ms);
            has = 1'b1;
          end
        end
        roa_pkg::REQ_TICK: begin
          if (running) begin
            has = 1'b1;
            since = w.now_ms - sample_ms;
            if (since >= {16'd0, cfg.sensor_period_ms}) begin
              held = w.flags;
              sample_ms = w.now_ms;
            end
            fl = held[roa_pkg::FL_IDX];
            fc = held[roa_pkg::FC_IDX];
            fr = held[roa_pkg::FR_IDX];
            ls = held[roa_pkg::LS_IDX];
            rs = held[roa_pkg::RS_IDX];
            any_front = fl | fc | fr;
            case (nav)
              roa_pkg::NAV_FWD: begin
                if (any_front) begin
                  if (fl && !fr) switch_mode(roa_pkg::NAV_TURN_R, w.now_ms);
                  else if (!fl && fr) switch_mode(roa_pkg::NAV_TURN_L, w.now_ms);
                  else if (fc)
                    switch_mode(roa_pkg::roa_nav_t'(rs ? roa_pkg::NAV_TURN_L
                                                       : roa_pkg::NAV_TURN_R), w.now_ms);
                  else switch_mode(roa_pkg::NAV_TURN_L, w.now_ms);
                end else begin
                  r.motor_cmd = roa_pkg::CMD_FWD;
                  r.speed = cfg.cruise_speed;
                end
              end
              roa_pkg::NAV_WALL_L, roa_pkg::NAV_WALL_R: begin
                left = (nav == roa_pkg::NAV_WALL_L);
                if (fc) begin
                  switch_mode(roa_pkg::roa_nav_t'(left ? roa_pkg::NAV_TURN_R
                                                       : roa_pkg::NAV_TURN_L), w.now_ms);
                end else if (left ? ls : rs) begin
                  r.motor_cmd = roa_pkg::CMD_FWD;
                  r.speed = cfg.wall_speed;
                end else begin
                  r.motor_cmd = left ? roa_pkg::CMD_LEFT : roa_pkg::CMD_RIGHT;
                  r.speed = cfg.search_turn_speed;
                end
                since = w.now_ms - entry_ms;
                if (since > {16'd0, cfg.wall_follow_ms} && !any_front)
                  switch_mode(roa_pkg::NAV_FWD, w.now_ms);
              end
              roa_pkg::NAV_TURN_L, roa_pkg::NAV_TURN_R: begin
                left = (nav == roa_pkg::NAV_TURN_L);
                r.motor_cmd = left ? roa_pkg::CMD_LEFT : roa_pkg::CMD_RIGHT;
                r.speed = cfg.avoid_turn_speed;
                since = w.now_ms - entry_ms;
                if (since > {16'd0, cfg.turn_avoid_ms}) begin
                  if (!any_front) switch_mode(roa_pkg::NAV_FWD, w.now_ms);
                  else if (left ? ls : rs)
                    switch_mode(roa_pkg::roa_nav_t'(left ? roa_pkg::NAV_WALL_L
                                                         : roa_pkg::NAV_WALL_R), w.now_ms);
                  else entry_ms = w.now_ms;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
      if (has) begin
        r.nav_state = nav;
        pending_words.push_back(r);
      end
    endfunction

    function void check_word(roa_pkg::roa_result_t got);
      roa_pkg::roa_result_t want;
      if (pending_words.size() == 0) begin
        fail($sformatf("unexpected word: cmd %0d speed %0d state %0d",
                       got.motor_cmd, got.speed, got.nav_state));
        return;
      end
      want = pending_words.pop_front();
      if (got.motor_cmd !== want.motor_cmd || got.speed !== want.speed ||
          got.nav_state !== want.nav_state)
        fail($sformatf({"mismatch: cmd exp %0d got %0d, speed exp %0d got %0d, ",
                        "state exp %0d got %0d"},
                       want.motor_cmd, got.motor_cmd, want.speed, got.speed,
                       want.nav_state, got.nav_state));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [roa_pkg::ADDR_W-1:0] paddr;
  logic [roa_pkg::DATA_W-1:0] pwdata;
  logic [roa_pkg::DATA_W-1:0] prdata;
  logic pready;

  roa_in_if sensor_if();
  roa_out_if motor_if();

  motor_scoreboard sb = new();
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_hold = 0;
  logic [31:0] clock_ms = '0;
  int cycles = 0;

  reactive_obstacle_avoid_fsm i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .sensor(sensor_if),
    .motor(motor_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    roa_pkg::roa_result_t got;
    int gap;
    gap = 0;
    motor_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && motor_if.valid && motor_if.ready) begin
        got.motor_cmd = motor_if.motor_cmd;
        got.speed = motor_if.speed;
        got.nav_state = motor_if.nav_state;
        sb.check_word(got);
        gap = rx_idle_on ? $urandom_range(0, 6) : 0;
      end
      if (rst) begin
        motor_if.ready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold--;
        motor_if.ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        motor_if.ready <= 1'b0;
      end else begin
        motor_if.ready <= 1'b1;
      end
    end
  end

  function automatic roa_pkg::roa_item_t mk(logic [1:0] mode, logic [31:0] now,
                                            logic [FLAGS_W-1:0] flags);
    roa_pkg::roa_item_t w;
    w.mode = mode;
    w.now_ms = now;
    w.flags = flags;
    return w;
  endfunction

  task automatic send_word(roa_pkg::roa_item_t w);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      sensor_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sensor_if.valid <= 1'b1;
    sensor_if.mode <= w.mode;
    sensor_if.now_ms <= w.now_ms;
    sensor_if.front_left <= w.flags[roa_pkg::FL_IDX];
    sensor_if.front_center <= w.flags[roa_pkg::FC_IDX];
    sensor_if.front_right <= w.flags[roa_pkg::FR_IDX];
    sensor_if.left_side <= w.flags[roa_pkg::LS_IDX];
    sensor_if.right_side <= w.flags[roa_pkg::RS_IDX];
    do @(posedge clk); while (!sensor_if.ready);
    sb.note_word(w);
  endtask

  task automatic wait_drained();
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(index, value);
    @(posedge clk);
  endtask

  task automatic apply_config(logic [31:0] sensor, logic [31:0] turn, logic [31:0] wall,
                              logic [31:0] cruise, logic [31:0] wall_spd,
                              logic [31:0] search, logic [31:0] avoid);
    wait_drained();
    write_reg(roa_pkg::REG_SENSOR_PERIOD, sensor);
    write_reg(roa_pkg::REG_TURN_AVOID, turn);
    write_reg(roa_pkg::REG_WALL_FOLLOW, wall);
    write_reg(roa_pkg::REG_CRUISE_SPEED, cruise);
    write_reg(roa_pkg::REG_WALL_SPEED, wall_spd);
    write_reg(roa_pkg::REG_SEARCH_SPEED, search);
    write_reg(roa_pkg::REG_AVOID_SPEED, avoid);
  endtask

  // Mostly running ticks with random flags; stops, restarts and stray codes mixed in.
  task automatic run_random(int count, int step_max, bit with_hold, bit with_drain);
    roa_pkg::roa_item_t w;
    int pick;
    for (int k = 0; k < count; k++) begin
      if (k % 64 == 0) begin
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      if (with_hold && k == count / 3) rx_hold = 300;
      if (with_drain && k == count / 2) begin
        sensor_if.valid <= 1'b0;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (!sb.running)
        w.mode = pick < 60 ? roa_pkg::REQ_START : pick < 70 ? roa_pkg::REQ_STOP :
                 pick < 80 ? REQ_UNUSED : roa_pkg::REQ_TICK;
      else
        w.mode = pick < 3 ? roa_pkg::REQ_STOP : pick < 5 ? roa_pkg::REQ_START :
                 pick < 7 ? REQ_UNUSED : roa_pkg::REQ_TICK;
      if ($urandom_range(0, 99) == 0) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      w.now_ms = clock_ms;
      pick = $urandom_range(0, 9);
      if (pick < 4) w.flags = '0;
      else if (pick < 6) w.flags = $urandom_range(0, 1) ? F_LS : F_RS;
      else w.flags = FLAGS_W'($urandom());
      send_word(w);
    end
    sensor_if.valid <= 1'b0;
  endtask

  initial begin
    roa_pkg::roa_item_t directed[$];
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    sensor_if.valid <= 1'b0;
    sensor_if.mode <= roa_pkg::REQ_TICK;
    sensor_if.now_ms <= '0;
    sensor_if.front_left <= 1'b0;
    sensor_if.front_center <= 1'b0;
    sensor_if.front_right <= 1'b0;
    sensor_if.left_side <= 1'b0;
    sensor_if.right_side <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd10, F_ALL));
    directed.push_back(mk(roa_pkg::REQ_STOP, 32'd12, '0));
    directed.push_back(mk(REQ_UNUSED, 32'hFFFF_FFFF, F_ALL));
    directed.push_back(mk(roa_pkg::REQ_START, 32'd0, '0));
    directed.push_back(mk(roa_pkg::REQ_START, 32'd5, '0));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd20, F_FL));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd60, F_FL));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd100, '0));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd600, F_FC | F_RS));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd700, F_RS));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd800, '0));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd3700, '0));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd3800, F_FR));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd4400, F_FL | F_FR | F_LS));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd4500, F_LS));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd4600, F_FC));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd5200, F_FL | F_FC | F_FR));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd5800, '0));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd5900, F_FL | F_FC | F_FR | F_RS));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd6600, '0));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd6700, F_FL | F_FR));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'd6800, F_FC));
    directed.push_back(mk(roa_pkg::REQ_STOP, 32'd6900, '0));
    directed.push_back(mk(roa_pkg::REQ_START, 32'hFFFF_FFF0, '0));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'h0000_0030, '0));
    directed.push_back(mk(roa_pkg::REQ_TICK, 32'hFFFF_FFFF, F_ALL));
    foreach (directed[i]) send_word(directed[i]);
    sensor_if.valid <= 1'b0;
    clock_ms = 32'hFFFF_FFFF;

    apply_config(32'd1, 32'd10, 32'd40, $urandom(), $urandom(), $urandom(), $urandom());
    write_reg(REG_COUNT, $urandom());
    run_random(300, 12, 1'b1, 1'b0);

    apply_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    run_random(300, 3, 1'b0, 1'b1);

    apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(300, 30000, 1'b0, 1'b0);

    apply_config($urandom_range(1, 20), $urandom_range(0, 100), $urandom_range(0, 300),
                 $urandom(), $urandom(), $urandom(), $urandom());
    run_random(300, 40, 1'b1, 1'b1);

    apply_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom());
    run_random(300, 70000, 1'b0, 1'b0);

    apply_config(32'(roa_pkg::SENSOR_PERIOD_RST), 32'(roa_pkg::TURN_AVOID_RST),
                 32'(roa_pkg::WALL_FOLLOW_RST), 32'(roa_pkg::CRUISE_SPEED_RST),
                 32'(roa_pkg::WALL_SPEED_RST), 32'(roa_pkg::SEARCH_SPEED_RST),
                 32'(roa_pkg::AVOID_SPEED_RST));
    run_random(300, 200, 1'b0, 1'b0);

    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending_words.size() != 0)
      sb.fail($sformatf("%0d words never arrived", sb.pending_words.size()));
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/roa_pkg.sv
rtl/roa_if.sv
rtl/roa_nav_core.sv
rtl/reactive_obstacle_avoid_fsm.sv
rtl/roa_checker.sv
test/tb_reactive_obstacle_avoid_fsm.sv
